[hw/rtl/rf_dimmer_pulse_frame_decoder_assert.svh]
// Assertion macros for the dimmer frame decoder.
`ifndef RF_DIMMER_PULSE_FRAME_DECODER_ASSERT_SVH
`define RF_DIMMER_PULSE_FRAME_DECODER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define RFDPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RFDPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rfdpf_pkg.sv]
// Package: constants and types of the dimmer frame decoder.
`timescale 1ns / 1ps

package rfdpf_pkg;

    localparam int PULSE_W = 16;
    localparam int CFG_W   = 16;
    localparam int CNT_W   = 8;
    localparam int SHIFT_W = 37;
    localparam int ID_W    = 26;
    localparam int NIB_W   = 4;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 2;

    localparam logic [CNT_W-1:0] LEN_LONG  = CNT_W'(148);
    localparam logic [CNT_W-1:0] LEN_SHORT = CNT_W'(132);
    localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(149);

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BAD_LENGTH = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BAD_START  = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_BAD_FOOTER = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_BIT_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] REG_START_MIN     = 2'd1;
    localparam logic [IDX_W-1:0] REG_FOOTER_MIN    = 2'd2;
    localparam logic [IDX_W-1:0] REG_FOOTER_MAX    = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0] BIT_THRESHOLD_RST = CFG_W'(600);
    localparam logic [CFG_W-1:0] START_MIN_RST     = CFG_W'(2400);
    localparam logic [CFG_W-1:0] FOOTER_MIN_RST    = CFG_W'(8500);
    localparam logic [CFG_W-1:0] FOOTER_MAX_RST    = CFG_W'(10880);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   device_id;
        logic              all_units;
        logic              switch_on;
        logic [NIB_W-1:0]  unit_code;
        logic              has_dimlevel;
        logic [NIB_W-1:0]  dim_level;
    } result_t;

endpackage

[hw/rtl/rf_dimmer_pulse_frame_decoder.sv]
// Top level: pulse-by-pulse decoder of self-learning 433 MHz dimmer frames.
`timescale 1ns / 1ps

// Takes one measured pulse duration per request and returns one decoded
// result per frame, on the request marked end_of_frame. Pulses are counted
// from 0; bit k of the frame is pulse 4k+3 compared against the bit
// threshold. A frame is good when it is 132 or 148 pulses long, pulse 1 is
// at least start_min_us and the final gap lies within the footer bounds;
// otherwise the status names the first failing check and all other fields
// are zero. Each request updates the frame registers directly, and on the
// final pulse the result is decoded in the same cycle into the output
// register, so one request per cycle is sustained as long as results are
// taken (s_ready drops only while a result waits and m_ready is low).
// m_valid rises in the cycle after the final pulse is accepted.
// Configuration writes through cfg_we/cfg_index/cfg_wdata take effect at
// the next edge and are meant to happen only while the block is idle.
module rf_dimmer_pulse_frame_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_we,
    input  logic [rfdpf_pkg::IDX_W-1:0]   cfg_index,
    input  logic [rfdpf_pkg::CFG_W-1:0]   cfg_wdata,
    // pulse requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rfdpf_pkg::PULSE_W-1:0] s_pulse_us,
    input  logic                          s_end_of_frame,
    // decoded frames
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rfdpf_pkg::STAT_W-1:0]  m_status,
    output logic [rfdpf_pkg::ID_W-1:0]    m_device_id,
    output logic                          m_all_units,
    output logic                          m_switch_on,
    output logic [rfdpf_pkg::NIB_W-1:0]   m_unit_code,
    output logic                          m_has_dimlevel,
    output logic [rfdpf_pkg::NIB_W-1:0]   m_dim_level
);

    import rfdpf_pkg::*;

    `include "rf_dimmer_pulse_frame_decoder_assert.svh"

    // configuration registers
    logic [CFG_W-1:0] bit_threshold_reg;
    logic [CFG_W-1:0] start_min_reg;
    logic [CFG_W-1:0] footer_min_reg;
    logic [CFG_W-1:0] footer_max_reg;

    // frame state
    logic [CNT_W-1:0]   pulse_count_reg, pulse_count_next;
    logic [SHIFT_W-1:0] bit_shift_reg, bit_shift_next;
    logic               start_ok_reg, start_ok_next;

    // output stage
    logic    m_valid_reg, m_valid_next;
    result_t result_reg, result_next;

    logic               accept;
    logic               take_bit;
    logic [CNT_W-1:0]   count_upd;
    logic [SHIFT_W-1:0] shift_upd;
    logic               start_upd;
    logic [STAT_W-1:0]  status;
    result_t            decoded;
    logic               result_blank;
    logic               frame_cleared;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_threshold_reg <= BIT_THRESHOLD_RST;
            start_min_reg     <= START_MIN_RST;
            footer_min_reg    <= FOOTER_MIN_RST;
            footer_max_reg    <= FOOTER_MAX_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BIT_THRESHOLD: bit_threshold_reg <= cfg_wdata;
                REG_START_MIN:     start_min_reg     <= cfg_wdata;
                REG_FOOTER_MIN:    footer_min_reg    <= cfg_wdata;
                REG_FOOTER_MAX:    footer_max_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- per-pulse update ----------------
    // Data pulses are 3, 7, 11, ...; none taken past pulse 147.
    assign take_bit  = (pulse_count_reg < LEN_LONG) && (pulse_count_reg[1:0] == 2'b11);
    assign count_upd = (pulse_count_reg < COUNT_SAT) ? pulse_count_reg + CNT_W'(1)
                                                     : pulse_count_reg;
    assign shift_upd = take_bit ? {bit_shift_reg[SHIFT_W-2:0], (s_pulse_us > bit_threshold_reg)}
                                : bit_shift_reg;
    assign start_upd = (pulse_count_reg == CNT_W'(1)) ? (s_pulse_us >= start_min_reg)
                                                      : start_ok_reg;

    // ---------------- end-of-frame checks ----------------
    always_comb begin
        if (count_upd != LEN_LONG && count_upd != LEN_SHORT) begin
            status = STATUS_BAD_LENGTH;
        end else if (!start_upd) begin
            status = STATUS_BAD_START;
        end else if (s_pulse_us < footer_min_reg || s_pulse_us > footer_max_reg) begin
            status = STATUS_BAD_FOOTER;
        end else begin
            status = STATUS_OK;
        end
    end

    // Field extraction: first received bit is the MSB of the taken bits.
    // Long frame holds 37 bits, short frame 33; the footer bit is bit 0.
    always_comb begin
        decoded        = '0;
        decoded.status = status;
        if (status == STATUS_OK) begin
            if (count_upd == LEN_LONG) begin
                decoded.device_id    = shift_upd[36:11];
                decoded.all_units    = shift_upd[10];
                decoded.switch_on    = 1'b1;
                decoded.unit_code    = shift_upd[8:5];
                decoded.has_dimlevel = 1'b1;
                decoded.dim_level    = shift_upd[4:1];
            end else begin
                decoded.device_id = shift_upd[32:7];
                decoded.all_units = shift_upd[6];
                decoded.switch_on = shift_upd[5];
                decoded.unit_code = shift_upd[4:1];
            end
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        pulse_count_next = pulse_count_reg;
        bit_shift_next   = bit_shift_reg;
        start_ok_next    = start_ok_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        result_next      = result_reg;
        if (accept) begin
            if (s_end_of_frame) begin
                // frame done: clear for the next one
                pulse_count_next = '0;
                bit_shift_next   = '0;
                start_ok_next    = 1'b0;
                m_valid_next     = 1'b1;
                result_next      = decoded;
            end else begin
                pulse_count_next = count_upd;
                bit_shift_next   = shift_upd;
                start_ok_next    = start_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_count_reg <= '0;
            bit_shift_reg   <= '0;
            start_ok_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            pulse_count_reg <= pulse_count_next;
            bit_shift_reg   <= bit_shift_next;
            start_ok_reg    <= start_ok_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload register, no reset
    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = result_reg.status;
    assign m_device_id    = result_reg.device_id;
    assign m_all_units    = result_reg.all_units;
    assign m_switch_on    = result_reg.switch_on;
    assign m_unit_code    = result_reg.unit_code;
    assign m_has_dimlevel = result_reg.has_dimlevel;
    assign m_dim_level    = result_reg.dim_level;

    // ---------------- assertions ----------------
    assign result_blank  = (result_reg.device_id == '0) && (result_reg.unit_code == '0)
                           && !result_reg.has_dimlevel && (result_reg.dim_level == '0);
    assign frame_cleared = (pulse_count_reg == '0) && !start_ok_reg;

    `RFDPF_ASSERT(a_count_sat, pulse_count_reg <= COUNT_SAT, "pulse count above saturation")
    `RFDPF_ASSERT(a_fail_zero, !m_valid_reg || result_reg.status == STATUS_OK || result_blank, "failed frame carries data")
    `RFDPF_ASSERT(a_dim_on, !m_valid_reg || !result_reg.has_dimlevel || result_reg.switch_on, "dim level without switch on")
    `RFDPF_ASSERT_NEXT(a_eof_clear, accept && s_end_of_frame, m_valid_reg && frame_cleared, "frame end not cleared")

endmodule

[bench/rf_dimmer_pulse_frame_decoder_tb.sv]
// Testbench: self-checking random-frame test of the dimmer pulse frame decoder.
`timescale 1ns / 1ps

module rf_dimmer_pulse_frame_decoder_tb;
    import rfdpf_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 12;
    localparam int STALL_LIMIT = 5000;   // cycles with no request or result moving
    localparam int HOLD_CYC    = 400;    // long receiver hold-off
    localparam int DRAIN_CYC   = 10;     // drain time before the summary
    localparam int MIN_ITEMS   = 700;
    localparam int PULSE_MAX   = 65535;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_us;
        logic               end_of_frame;
    } pulse_req_t;

    // ------------------------------------------------------------------
    // DUT signals; the inputs are all known from time zero
    // ------------------------------------------------------------------
    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               cfg_we         = 1'b0;
    logic [IDX_W-1:0]   cfg_index      = '0;
    logic [CFG_W-1:0]   cfg_wdata      = '0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [PULSE_W-1:0] s_pulse_us     = '0;
    logic               s_end_of_frame = 1'b0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [STAT_W-1:0]  m_status;
    logic [ID_W-1:0]    m_device_id;
    logic               m_all_units;
    logic               m_switch_on;
    logic [NIB_W-1:0]   m_unit_code;
    logic               m_has_dimlevel;
    logic [NIB_W-1:0]   m_dim_level;

    rf_dimmer_pulse_frame_decoder u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pulse_us     (s_pulse_us),
        .s_end_of_frame (s_end_of_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_device_id    (m_device_id),
        .m_all_units    (m_all_units),
        .m_switch_on    (m_switch_on),
        .m_unit_code    (m_unit_code),
        .m_has_dimlevel (m_has_dimlevel),
        .m_dim_level    (m_dim_level)
    );

    initial forever #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------
    // Decoder mirror: register copies and per-frame state
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   thr_us       = BIT_THRESHOLD_RST;
    logic [CFG_W-1:0]   start_min_us = START_MIN_RST;
    logic [CFG_W-1:0]   foot_min_us  = FOOTER_MIN_RST;
    logic [CFG_W-1:0]   foot_max_us  = FOOTER_MAX_RST;
    logic [CNT_W-1:0]   pulse_idx    = '0;
    logic [SHIFT_W-1:0] frame_bits   = '0;
    logic               start_ok     = 1'b0;

    result_t    frames_due[$];   // decoded frames still owed by the DUT
    pulse_req_t pulse_q[$];      // pulse requests not yet offered

    int items_queued   = 0;
    int items_taken    = 0;
    int frames_checked = 0;
    int fail_cnt       = 0;
    int status_seen[4] = '{default: 0};

    // Advance the mirror by one accepted pulse; on the final gap, push the
    // decoded frame and clear for the next one.
    task automatic decode_pulse(input logic [PULSE_W-1:0] pulse, input logic eof);
        result_t            res;
        logic [SHIFT_W-1:0] aligned;
        if (pulse_idx == CNT_W'(1))
            start_ok = (pulse >= start_min_us);
        // bit k lives on pulse 4k+3; nothing is taken past pulse 147
        if (pulse_idx < LEN_LONG && pulse_idx[1:0] == 2'b11)
            frame_bits = {frame_bits[SHIFT_W-2:0], pulse > thr_us};
        if (pulse_idx < COUNT_SAT)
            pulse_idx = pulse_idx + CNT_W'(1);
        if (eof) begin
            res = '0;
            // first failing check wins: length, then start, then footer
            if (pulse_idx != LEN_LONG && pulse_idx != LEN_SHORT)
                res.status = STATUS_BAD_LENGTH;
            else if (!start_ok)
                res.status = STATUS_BAD_START;
            else if (pulse < foot_min_us || pulse > foot_max_us)
                res.status = STATUS_BAD_FOOTER;
            else
                res.status = STATUS_OK;
            if (res.status == STATUS_OK) begin
                // short frame has four bits fewer; shift up so both share one layout
                aligned = (pulse_idx == LEN_LONG) ? frame_bits : frame_bits << 4;
                res.device_id = aligned[36:11];
                res.all_units = aligned[10];
                res.switch_on = aligned[9];
                res.unit_code = aligned[8:5];
                if (pulse_idx == LEN_LONG) begin
                    res.has_dimlevel = 1'b1;
                    res.dim_level    = aligned[4:1];
                    res.switch_on    = 1'b1;   // dim level implies on
                end
            end
            frames_due.push_back(res);
            pulse_idx  = '0;
            frame_bits = '0;
            start_ok   = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Pulse generation
    // ------------------------------------------------------------------
    function automatic logic [PULSE_W-1:0] pick_range(input int unsigned lo,
                                                      input int unsigned hi);
        if (hi > PULSE_MAX) hi = PULSE_MAX;
        if (lo > hi) lo = hi;
        return PULSE_W'($urandom_range(hi, lo));
    endfunction

    // Data pulse on either side of the current threshold, edges now and then.
    function automatic logic [PULSE_W-1:0] bit_pulse(input bit one);
        int unsigned t;
        t = thr_us;
        if (one && t == PULSE_MAX)
            return PULSE_W'(PULSE_MAX);      // nothing can exceed it
        if ($urandom_range(7, 0) == 0)
            return one ? PULSE_W'(t + 1) : PULSE_W'(t);
        return one ? pick_range(t + 1, t + 1500) : pick_range(t > 400 ? t - 400 : 0, t);
    endfunction

    function automatic logic [PULSE_W-1:0] start_pulse(input bit good);
        int unsigned m;
        m = start_min_us;
        if (good || m == 0)
            return pick_range(m, m + 1000);
        return ($urandom_range(3, 0) == 0) ? PULSE_W'(m - 1) : pick_range(0, m - 1);
    endfunction

    function automatic logic [PULSE_W-1:0] footer_pulse();
        int unsigned lo, hi;
        lo = (foot_min_us < foot_max_us) ? foot_min_us : foot_max_us;
        hi = (foot_min_us < foot_max_us) ? foot_max_us : foot_min_us;
        case ($urandom_range(9, 0))
            0:       return foot_min_us;
            1:       return foot_max_us;
            2:       return (foot_min_us == 0) ? '0 : foot_min_us - 1'b1;
            3:       return pick_range(foot_max_us + 1, foot_max_us + 1);
            4:       return pick_range(0, PULSE_MAX);
            default: return pick_range(lo, hi);
        endcase
    endfunction

    task automatic queue_pulse(input logic [PULSE_W-1:0] pulse, input logic eof);
        pulse_q.push_back('{pulse_us: pulse, end_of_frame: eof});
        items_queued++;
    endtask

    // Shaped frame: short lead pulse, start pulse, data pulses, footer last.
    task automatic queue_frame(input int unsigned len, input bit start_good);
        logic [PULSE_W-1:0] p;
        for (int unsigned i = 0; i < len; i++) begin
            if (i == len - 1)
                p = footer_pulse();
            else if (i == 1)
                p = start_pulse(start_good);
            else if (i % 4 == 3)
                p = bit_pulse(1'($urandom_range(1, 0)));
            else if ($urandom_range(9, 0) == 0)
                p = pick_range(0, PULSE_MAX);
            else
                p = pick_range(200, 400);
            queue_pulse(p, i == len - 1);
        end
    endtask

    // Mostly well-formed frames, the rest off-by-one, very short, overlong or plain noise.
    task automatic queue_random_frame();
        int unsigned kind, len;
        kind = $urandom_range(99, 0);
        if (kind < 55) begin
            queue_frame($urandom_range(1, 0) ? 32'(LEN_LONG) : 32'(LEN_SHORT),
                        $urandom_range(9, 0) != 0);
        end else if (kind < 72) begin
            case ($urandom_range(4, 0))
                0:       len = 131;
                1:       len = 133;
                2:       len = 147;
                3:       len = 149;
                default: len = $urandom_range(12, 1);
            endcase
            queue_frame(len, 1'b1);
        end else if (kind < 82) begin
            queue_frame($urandom_range(210, 150), 1'b1);   // counter saturates
        end else begin
            len = $urandom_range(40, 1);
            for (int unsigned i = 0; i < len; i++)
                queue_pulse(pick_range(0, PULSE_MAX), i == len - 1);
        end
    endtask

    task automatic run_frames(input int n);
        repeat (n) queue_random_frame();
    endtask

    // ------------------------------------------------------------------
    // Register writes, only while idle
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_BIT_THRESHOLD: thr_us       = val;
            REG_START_MIN:     start_min_us = val;
            REG_FOOTER_MIN:    foot_min_us  = val;
            REG_FOOTER_MAX:    foot_max_us  = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] smin,
                              input logic [CFG_W-1:0] fmin, input logic [CFG_W-1:0] fmax);
        write_reg(REG_BIT_THRESHOLD, thr);
        write_reg(REG_START_MIN, smin);
        write_reg(REG_FOOTER_MIN, fmin);
        write_reg(REG_FOOTER_MAX, fmax);
        @(negedge aclk);
    endtask

    // Sender pauses here until every queued pulse is taken and every owed frame
    // is back, then waits on so a non-final pulse still in the block has settled.
    task automatic wait_idle();
        @(negedge aclk);
        while (pulse_q.size() != 0 || s_valid || frames_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    int         burst_left = 1;
    int         gap_left   = 0;
    pulse_req_t next_req;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_pulse(s_pulse_us, s_end_of_frame);
                items_taken++;
            end
            // valid holds with a steady payload until the request is taken
            if (!s_valid || s_ready) begin
                if (gap_left != 0 || pulse_q.size() == 0) begin
                    if (gap_left != 0) gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    next_req = pulse_q.pop_front();
                    s_valid        <= 1'b1;
                    s_pulse_us     <= next_req.pulse_us;
                    s_end_of_frame <= next_req.end_of_frame;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(40, 1);
                        // about a third of bursts run straight into the next
                        gap_left   = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(8, 1);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: rotating stall pattern plus an on-demand hold-off
    // ------------------------------------------------------------------
    logic       hold_req  = 1'b0;   // toggled by the stimulus process
    logic       hold_ack  = 1'b0;
    int         hold_left = 0;
    int         pat_left  = 0;
    logic [7:0] stall_pat = 8'hFF;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYC;
            end else if (hold_left != 0) begin
                hold_left--;
            end
            if (pat_left == 0) begin
                stall_pat = ($urandom_range(9, 0) < 3) ? 8'hFF : 8'($urandom());
                pat_left  = 32;
            end
            pat_left--;
            m_ready <= (hold_left == 0) && stall_pat[pat_left % 8];
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    result_t want;

    task automatic compare_field(input string fname, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, exp_val, act_val);
            fail_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                $error("result with no frame owed: status %0d", m_status);
                fail_cnt++;
            end else begin
                want = frames_due.pop_front();
                compare_field("status", 32'(want.status), 32'(m_status));
                compare_field("device_id", 32'(want.device_id), 32'(m_device_id));
                compare_field("all_units", 32'(want.all_units), 32'(m_all_units));
                compare_field("switch_on", 32'(want.switch_on), 32'(m_switch_on));
                compare_field("unit_code", 32'(want.unit_code), 32'(m_unit_code));
                compare_field("has_dimlevel", 32'(want.has_dimlevel), 32'(m_has_dimlevel));
                compare_field("dim_level", 32'(want.dim_level), 32'(m_dim_level));
                status_seen[want.status]++;
            end
            frames_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles, %0d frames owed",
                     STALL_LIMIT, frames_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: frames ending on pulse 0, 1 and 3, field extremes.
        queue_pulse(16'd0, 1'b1);
        queue_pulse(16'hFFFF, 1'b1);
        queue_pulse(16'hFFFF, 1'b0);
        queue_pulse(16'hFFFF, 1'b1);
        queue_pulse(16'd0, 1'b0);
        queue_pulse(16'd0, 1'b1);
        queue_pulse(16'd300, 1'b0);
        queue_pulse(16'd2400, 1'b0);
        queue_pulse(16'hFFFF, 1'b0);
        queue_pulse(16'd8500, 1'b1);

        // Reset register values.
        run_frames(1);
        wait_idle();

        // Low extremes: every nonzero data pulse is a one, any start passes.
        set_config('0, '0, '0, 16'hFFFF);
        queue_frame(32'(LEN_SHORT), 1'b1);
        wait_idle();

        // High extremes: data pulses are all zero, start and footer pinned.
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_frame(32'(LEN_SHORT), 1'b1);
        wait_idle();

        // Footer bounds crossed: no valid frame can pass the footer check.
        set_config(BIT_THRESHOLD_RST, START_MIN_RST, 16'd10000, 16'd9000);
        queue_frame(32'(LEN_SHORT), 1'b1);
        wait_idle();

        // One random register set with a long frame.
        set_config(pick_range(200, 2000), pick_range(1000, 4000),
                   pick_range(5000, 9000), pick_range(9000, 13000));
        queue_frame(32'(LEN_LONG), 1'b1);
        wait_idle();

        // Long hold-off on results while short frames keep coming, so the
        // output register fills and the block stalls requests.
        @(posedge aclk);
        hold_req <= ~hold_req;
        @(negedge aclk);
        repeat (20) queue_frame($urandom_range(6, 1), 1'b1);
        wait_idle();

        // Back to reset values; random frames up to the pulse budget.
        set_config(BIT_THRESHOLD_RST, START_MIN_RST, FOOTER_MIN_RST, FOOTER_MAX_RST);
        while (items_queued < MIN_ITEMS)
            queue_random_frame();
        wait_idle();
        repeat (DRAIN_CYC) @(posedge aclk);

        $display("Covered %0d pulses, %0d frames: %0d good, %0d bad length, %0d bad start,",
                 items_taken, frames_checked, status_seen[STATUS_OK],
                 status_seen[STATUS_BAD_LENGTH], status_seen[STATUS_BAD_START]);
        $display("  %0d bad footer; register sweeps to both extremes, crossed footer bounds.",
                 status_seen[STATUS_BAD_FOOTER]);
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
